@@ rtl/core/gda_pkg.sv @@
// ----------------------------------------------------------------------------
// gda_pkg
// shared types, constants and the month length helper for the date block
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int SER_W  = 24;   // day serial numbers and the working remainder
    localparam int KW_W   = 18;   // loop step constants
    localparam int STEP_W = 5;    // microprogram counter
    localparam int CNT_W  = 6;    // loop iteration counter
    localparam int FVAL_W = 9;    // flag compare value

    typedef logic [SER_W-1:0]  t_ser;
    typedef logic [KW_W-1:0]   t_kw;
    typedef logic [STEP_W-1:0] t_step;
    typedef logic [CNT_W-1:0]  t_cnt;

    // selector codes
    localparam logic [1:0] FUNC_ADD  = 2'd0;
    localparam logic [1:0] FUNC_SUB  = 2'd1;
    localparam logic [1:0] FUNC_DIFF = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // days in 400, 100, 4 and 1 years of the proleptic calendar
    localparam t_kw DAYS_400Y = 18'd146097;
    localparam t_kw DAYS_100Y = 18'd36524;
    localparam t_kw DAYS_4Y   = 18'd1461;
    localparam t_kw DAYS_1Y   = 18'd365;

    localparam logic [4:0] MONTH_LEN [13] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // microprogram addresses
    localparam t_step ST_INIT   = 5'd0;
    localparam t_step ST_Y400   = 5'd1;
    localparam t_step ST_Y100   = 5'd2;
    localparam t_step ST_Y4     = 5'd3;
    localparam t_step ST_Y1     = 5'd4;
    localparam t_step ST_MINIT  = 5'd5;
    localparam t_step ST_MWALK  = 5'd6;
    localparam t_step ST_ADDD   = 5'd7;
    localparam t_step ST_SAVE   = 5'd8;
    localparam t_step ST_SHIFT  = 5'd9;
    localparam t_step ST_F400   = 5'd10;
    localparam t_step ST_F100   = 5'd11;
    localparam t_step ST_F4     = 5'd12;
    localparam t_step ST_F1     = 5'd13;
    localparam t_step ST_FMINIT = 5'd14;
    localparam t_step ST_FMWALK = 5'd15;
    localparam t_step ST_FDONE  = 5'd16;
    localparam t_step ST_DIFF   = 5'd17;
    localparam t_step ST_ERR    = 5'd18;

    typedef enum logic [3:0] {
        OP_INIT,
        OP_LOOP,
        OP_MINIT,
        OP_MWALK,
        OP_ADDDAY,
        OP_SAVE,
        OP_SHIFT,
        OP_FMINIT,
        OP_FMWALK,
        OP_RES_OK,
        OP_RES_DIFF,
        OP_RES_ERR
    } t_op;

    typedef enum logic [2:0] {
        JC_NEVER,
        JC_BAD,
        JC_DAYBAD,
        JC_SEL1,
        JC_FUNC2,
        JC_UNDER,
        JC_YEARBAD
    } t_jc;

    typedef enum logic [1:0] {
        FL_NONE,
        FL_A,
        FL_B,
        FL_C
    } t_fl;

    // one control word of the microprogram
    typedef struct packed {
        t_op               op;
        t_jc               jc;
        t_step             target;
        t_kw               k;       // amount taken from the remainder per pass
        t_kw               w;       // amount added to the accumulator per pass
        logic              cap3;    // loop stops after three passes
        t_fl               fdst;    // flag written at loop exit
        logic              fcnt;    // flag compares pass count, else remainder
        logic [FVAL_W-1:0] fval;
    } t_cw;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic hold;
        logic done;
        logic bad;
        logic daybad;
        logic sel1;
        logic func2;
        logic under;
        logic yearbad;
    } t_stat;

    function automatic logic [4:0] f_dim(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        if (m == 4'd2) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (m >= 4'd1 && m <= 4'd12) begin
            len = MONTH_LEN[m];
        end else begin
            len = MONTH_LEN[0];
        end
        return len;
    endfunction

endpackage

@@ rtl/core/gda_rom.sv @@
// ----------------------------------------------------------------------------
// gda_rom
// microprogram store: one control word per step address
// ----------------------------------------------------------------------------
module gda_rom
    import gda_pkg::*;
(
    input  t_step i_step,
    output t_cw   o_cw
);

    t_cw cw;

    always_comb begin
        cw = '0;
        case (i_step)
            ST_INIT: begin
                cw.op = OP_INIT;    cw.jc = JC_BAD;    cw.target = ST_ERR;
            end
            // date to serial: whole eras, centuries, quads, years
            ST_Y400: begin
                cw.op = OP_LOOP;    cw.k = 18'd400; cw.w = DAYS_400Y;
                cw.fdst = FL_A;     cw.fval = 9'd399;
            end
            ST_Y100: begin
                cw.op = OP_LOOP;    cw.k = 18'd100; cw.w = DAYS_100Y;
                cw.fdst = FL_B;     cw.fval = 9'd99;
            end
            ST_Y4: begin
                cw.op = OP_LOOP;    cw.k = 18'd4;   cw.w = DAYS_4Y;
                cw.fdst = FL_C;     cw.fval = 9'd3;
            end
            ST_Y1: begin
                cw.op = OP_LOOP;    cw.k = 18'd1;   cw.w = DAYS_1Y;
            end
            ST_MINIT: begin
                cw.op = OP_MINIT;   cw.jc = JC_DAYBAD; cw.target = ST_ERR;
            end
            ST_MWALK: begin
                cw.op = OP_MWALK;
            end
            ST_ADDD: begin
                cw.op = OP_ADDDAY;  cw.jc = JC_SEL1;   cw.target = ST_DIFF;
            end
            ST_SAVE: begin
                cw.op = OP_SAVE;    cw.jc = JC_FUNC2;  cw.target = ST_INIT;
            end
            ST_SHIFT: begin
                cw.op = OP_SHIFT;   cw.jc = JC_UNDER;  cw.target = ST_ERR;
            end
            // serial to date
            ST_F400: begin
                cw.op = OP_LOOP;    cw.k = DAYS_400Y; cw.w = 18'd400;
            end
            ST_F100: begin
                cw.op = OP_LOOP;    cw.k = DAYS_100Y; cw.w = 18'd100; cw.cap3 = 1'b1;
                cw.fdst = FL_A;     cw.fcnt = 1'b1;   cw.fval = 9'd3;
            end
            ST_F4: begin
                cw.op = OP_LOOP;    cw.k = DAYS_4Y;   cw.w = 18'd4;
                cw.fdst = FL_B;     cw.fcnt = 1'b1;   cw.fval = 9'd24;
            end
            ST_F1: begin
                cw.op = OP_LOOP;    cw.k = DAYS_1Y;   cw.w = 18'd1;   cw.cap3 = 1'b1;
                cw.fdst = FL_C;     cw.fcnt = 1'b1;   cw.fval = 9'd3;
            end
            ST_FMINIT: begin
                cw.op = OP_FMINIT;
            end
            ST_FMWALK: begin
                cw.op = OP_FMWALK;  cw.jc = JC_YEARBAD; cw.target = ST_ERR;
            end
            ST_FDONE: begin
                cw.op = OP_RES_OK;
            end
            ST_DIFF: begin
                cw.op = OP_RES_DIFF;
            end
            ST_ERR: begin
                cw.op = OP_RES_ERR;
            end
            default: begin
                cw.op = OP_RES_ERR;
            end
        endcase
    end

    assign o_cw = cw;

endmodule

@@ rtl/core/gda_seq.sv @@
// ----------------------------------------------------------------------------
// gda_seq
// step counter with loop hold and conditional jumps
// ----------------------------------------------------------------------------
module gda_seq
    import gda_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_cw   i_cw,
    input  t_stat i_stat,
    output t_step o_step,
    output logic  o_busy
);

    logic  r_busy, n_busy;
    t_step r_step, n_step;
    logic  jump;

    always_comb begin
        case (i_cw.jc)
            JC_NEVER:   jump = 1'b0;
            JC_BAD:     jump = i_stat.bad;
            JC_DAYBAD:  jump = i_stat.daybad;
            JC_SEL1:    jump = i_stat.sel1;
            JC_FUNC2:   jump = i_stat.func2;
            JC_UNDER:   jump = i_stat.under;
            JC_YEARBAD: jump = i_stat.yearbad;
            default:    jump = 1'b0;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = ST_INIT;
        end else if (r_busy) begin
            if (i_stat.hold) begin
                n_step = r_step;
            end else if (i_stat.done) begin
                n_busy = 1'b0;
            end else if (jump) begin
                n_step = i_cw.target;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= ST_INIT;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    assign o_step = r_step;
    assign o_busy = r_busy;

endmodule

@@ rtl/core/gda_dp.sv @@
// ----------------------------------------------------------------------------
// gda_dp
// date datapath: remainder, accumulator, month walker, flags, result register
// ----------------------------------------------------------------------------
module gda_dp
    import gda_pkg::*;
#(
    parameter int YEAR_MAX = 9999
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic        i_en,
    input  t_cw         i_cw,
    input  logic [1:0]  i_func,
    input  logic [13:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [15:0] i_day_count,
    input  logic [13:0] i_other_year,
    input  logic [3:0]  i_other_month,
    input  logic [4:0]  i_other_day,
    input  logic        i_out_stall,
    output t_stat       o_stat,
    output logic        o_valid,
    output logic [13:0] o_res_year,
    output logic [3:0]  o_res_month,
    output logic [4:0]  o_res_day,
    output logic [21:0] o_day_difference,
    output logic        o_is_less,
    output logic        o_is_equal,
    output logic        o_error
);

    localparam logic [15:0] YMAX = 16'(YEAR_MAX);

    // captured beat
    logic [1:0]  r_func;
    logic [13:0] r_y1, r_y2;
    logic [3:0]  r_m1, r_m2;
    logic [4:0]  r_d1, r_d2;
    logic [15:0] r_cnt_in;
    logic        r_less, r_equal;

    // working registers
    logic        r_sel;
    t_ser        r_a, r_s, r_s1;
    t_cnt        r_cnt;
    logic [3:0]  r_m;
    logic        r_fa, r_fb, r_fc;

    // result register
    logic        r_ovalid;
    logic [13:0] r_oyear;
    logic [3:0]  r_omonth;
    logic [4:0]  r_oday;
    logic [21:0] r_odiff;
    logic        r_oless, r_oequal, r_oerr;

    logic        in_less;
    logic [13:0] ysel;
    logic [3:0]  msel;
    logic [4:0]  dsel;
    logic        leap, basic_ok, out_free;
    logic        loop_go, ts_go, fm_go, flag_v;
    logic [4:0]  mlen;
    logic        res_op;

    always_comb begin
        if (i_year != i_other_year) begin
            in_less = i_year < i_other_year;
        end else if (i_month != i_other_month) begin
            in_less = i_month < i_other_month;
        end else begin
            in_less = i_day < i_other_day;
        end
    end

    assign ysel = r_sel ? r_y2 : r_y1;
    assign msel = r_sel ? r_m2 : r_m1;
    assign dsel = r_sel ? r_d2 : r_d1;

    // flags a, b, c: century-of-era, century, year-of-quad boundary marks
    assign leap     = r_fc && (!r_fb || r_fa);
    assign basic_ok = (ysel != 14'd0) && ({2'b00, ysel} <= YMAX) &&
                      (msel >= 4'd1) && (msel <= 4'd12) && (dsel != 5'd0);
    assign out_free = !r_ovalid || !i_out_stall;

    assign loop_go = (r_a >= {{(SER_W-KW_W){1'b0}}, i_cw.k}) &&
                     (!i_cw.cap3 || r_cnt < CNT_W'(3));
    assign mlen    = f_dim(r_m, leap);
    assign ts_go   = r_m < msel;
    assign fm_go   = (r_m < 4'd12) && (r_a >= {{(SER_W-5){1'b0}}, mlen});
    assign flag_v  = i_cw.fcnt ? (r_cnt == i_cw.fval[CNT_W-1:0])
                               : (r_a == {{(SER_W-FVAL_W){1'b0}}, i_cw.fval});
    assign res_op  = (i_cw.op == OP_RES_OK) || (i_cw.op == OP_RES_DIFF) ||
                     (i_cw.op == OP_RES_ERR);

    always_comb begin
        case (i_cw.op)
            OP_LOOP:     o_stat.hold = loop_go;
            OP_MWALK:    o_stat.hold = ts_go;
            OP_FMWALK:   o_stat.hold = fm_go;
            OP_RES_OK,
            OP_RES_DIFF,
            OP_RES_ERR:  o_stat.hold = !out_free;
            default:     o_stat.hold = 1'b0;
        endcase
        o_stat.done    = res_op && out_free;
        o_stat.bad     = !basic_ok || (r_func == FUNC_NONE) || (r_sel && r_less);
        o_stat.daybad  = dsel > f_dim(msel, leap);
        o_stat.sel1    = r_sel;
        o_stat.func2   = r_func == FUNC_DIFF;
        o_stat.under   = (r_func == FUNC_SUB) && ({8'd0, r_cnt_in} > r_s);
        o_stat.yearbad = r_s > {8'd0, YMAX};
    end

    // beat capture and datapath operations
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_func   <= i_func;
            r_y1     <= i_year;
            r_m1     <= i_month;
            r_d1     <= i_day;
            r_cnt_in <= i_day_count;
            r_y2     <= i_other_year;
            r_m2     <= i_other_month;
            r_d2     <= i_other_day;
            r_less   <= in_less;
            r_equal  <= (i_year == i_other_year) && (i_month == i_other_month) &&
                        (i_day == i_other_day);
            r_sel    <= 1'b0;
        end else if (i_en) begin
            case (i_cw.op)
                OP_INIT: begin
                    r_a   <= {{(SER_W-14){1'b0}}, ysel} - 1'b1;
                    r_s   <= '0;
                    r_cnt <= '0;
                    r_fa  <= 1'b0;
                    r_fb  <= 1'b0;
                    r_fc  <= 1'b0;
                end
                OP_LOOP: begin
                    if (loop_go) begin
                        r_a   <= r_a - {{(SER_W-KW_W){1'b0}}, i_cw.k};
                        r_s   <= r_s + {{(SER_W-KW_W){1'b0}}, i_cw.w};
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_cnt <= '0;
                        case (i_cw.fdst)
                            FL_A:    r_fa <= flag_v;
                            FL_B:    r_fb <= flag_v;
                            FL_C:    r_fc <= flag_v;
                            default: ;
                        endcase
                    end
                end
                OP_MINIT: begin
                    r_m <= 4'd1;
                end
                OP_MWALK: begin
                    if (ts_go) begin
                        r_s <= r_s + {{(SER_W-5){1'b0}}, mlen};
                        r_m <= r_m + 1'b1;
                    end
                end
                OP_ADDDAY: begin
                    r_s <= r_s + {{(SER_W-5){1'b0}}, dsel} - 1'b1;
                end
                OP_SAVE: begin
                    r_s1  <= r_s;
                    r_sel <= 1'b1;
                end
                OP_SHIFT: begin
                    if (r_func == FUNC_ADD) begin
                        r_a <= r_s + {8'd0, r_cnt_in};
                    end else begin
                        r_a <= r_s - {8'd0, r_cnt_in};
                    end
                    r_s   <= '0;
                    r_cnt <= '0;
                    r_fa  <= 1'b0;
                    r_fb  <= 1'b0;
                    r_fc  <= 1'b0;
                end
                OP_FMINIT: begin
                    r_s <= r_s + 1'b1;
                    r_m <= 4'd1;
                end
                OP_FMWALK: begin
                    if (fm_go) begin
                        r_a <= r_a - {{(SER_W-5){1'b0}}, mlen};
                        r_m <= r_m + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_en && res_op && out_free) begin
            r_oless  <= r_less;
            r_oequal <= r_equal;
            case (i_cw.op)
                OP_RES_OK: begin
                    r_oyear  <= r_s[13:0];
                    r_omonth <= r_m;
                    r_oday   <= r_a[4:0] + 1'b1;
                    r_odiff  <= '0;
                    r_oerr   <= 1'b0;
                end
                OP_RES_DIFF: begin
                    r_oyear  <= r_y1;
                    r_omonth <= r_m1;
                    r_oday   <= r_d1;
                    r_odiff  <= 22'(r_s1 - r_s);
                    r_oerr   <= 1'b0;
                end
                default: begin
                    r_oyear  <= r_y1;
                    r_omonth <= r_m1;
                    r_oday   <= r_d1;
                    r_odiff  <= '0;
                    r_oerr   <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_en && res_op && out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_res_year       = r_oyear;
    assign o_res_month      = r_omonth;
    assign o_res_day        = r_oday;
    assign o_day_difference = r_odiff;
    assign o_is_less        = r_oless;
    assign o_is_equal       = r_oequal;
    assign o_error          = r_oerr;

endmodule

@@ rtl/core/gregorian_date_arithmetic_top.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_top
// date add, subtract and day difference run by a small microprogram
// ----------------------------------------------------------------------------
// throughput: one beat at a time, the next taken the cycle after the result is
//   registered; set by the data-dependent subtract loops
//   (eras, centuries, quads, years, months) on the shared remainder register
// a finished result sits in the output register, so the next beat is taken
//   while that result is still stalled
// reset: synchronous active low, clears the sequencer and output valid
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_top
    import gda_pkg::*;
#(
    parameter int YEAR_MAX = 9999
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // input beat
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [13:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [15:0] i_day_count,
    input  logic [13:0] i_other_year,
    input  logic [3:0]  i_other_month,
    input  logic [4:0]  i_other_day,

    // result beat
    output logic        o_valid,
    input  logic        i_stall,
    output logic [13:0] o_res_year,
    output logic [3:0]  o_res_month,
    output logic [4:0]  o_res_day,
    output logic [21:0] o_day_difference,
    output logic        o_is_less,
    output logic        o_is_equal,
    output logic        o_error
);

    // sequencer, microprogram and datapath wiring
    t_step w_step;
    t_cw   w_cw;
    t_stat w_stat;
    logic  w_busy;
    logic  w_start;

    // the block takes a beat only when no microprogram is running
    assign o_stall = w_busy;
    assign w_start = i_valid && !w_busy;

    gda_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_cw    (w_cw),
        .i_stat  (w_stat),
        .o_step  (w_step),
        .o_busy  (w_busy)
    );

    // control store: addressed by the step counter
    gda_rom u_rom (
        .i_step (w_step),
        .o_cw   (w_cw)
    );

    // datapath: a pass turns a date into a day serial, a second pass serves
    // the difference, and the shift path turns the moved serial back
    gda_dp #(
        .YEAR_MAX (YEAR_MAX)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (w_start),
        .i_en             (w_busy),
        .i_cw             (w_cw),
        .i_func           (i_func),
        .i_year           (i_year),
        .i_month          (i_month),
        .i_day            (i_day),
        .i_day_count      (i_day_count),
        .i_other_year     (i_other_year),
        .i_other_month    (i_other_month),
        .i_other_day      (i_other_day),
        .i_out_stall      (i_stall),
        .o_stat           (w_stat),
        .o_valid          (o_valid),
        .o_res_year       (o_res_year),
        .o_res_month      (o_res_month),
        .o_res_day        (o_res_day),
        .o_day_difference (o_day_difference),
        .o_is_less        (o_is_less),
        .o_is_equal       (o_is_equal),
        .o_error          (o_error)
    );

    // a completed microprogram always leaves a result beat behind
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_busy && w_stat.done) |=> o_valid)
        else $error("finished program left no result beat");

    // an error result never carries a day count
    a_err_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_day_difference == 22'd0))
        else $error("error result with nonzero difference");

    // a good result holds a real month and day
    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_error) |->
            (o_res_month >= 4'd1 && o_res_month <= 4'd12 && o_res_day != 5'd0))
        else $error("good result with impossible month or day");

    // equal and less cannot both hold
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_equal) |-> !o_is_less)
        else $error("compare flags both set");

endmodule

@@ verif/gregorian_date_arithmetic_top_tb.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_top_tb
// self-checking bench for the date add, subtract and day difference block:
// a directed table of calendar corner cases, then randomized beats with
// bursty idling on both channels, each result checked against its typed row or the predictor
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_top_tb;
    import gda_pkg::*;

    localparam int YEAR_LIMIT   = 9999;
    localparam int RANDOM_BEATS = 75;
    localparam int CALM_BEATS   = 20;     // closing beats with no idling at all
    localparam int TAIL_CYCLES  = 250;    // above the worst-case block latency
    localparam int WATCHDOG     = 4000;   // cycles with no beat on either side

    // one result as the block presents it
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [21:0] span;
        logic        less;
        logic        same;
        logic        err;
    } date_result_t;

    // one input beat, with an optional hand-written expectation
    typedef struct packed {
        logic [1:0]   func;
        logic [13:0]  year;
        logic [3:0]   month;
        logic [4:0]   day;
        logic [15:0]  count;
        logic [13:0]  other_year;
        logic [3:0]   other_month;
        logic [4:0]   other_day;
        logic         typed;
        date_result_t want;
    } date_beat_t;

    typedef struct packed {
        logic [31:0] y;
        logic [31:0] m;
        logic [31:0] d;
    } cal_date_t;

    // directed table; rows with typed set carry the result read straight off the
    // calendar, the rest go through the predictor
    localparam int DIR_ROWS = 25;
    localparam date_beat_t DIRECTED_ROWS [DIR_ROWS] = '{
        // unused selector, second date all ones
        '{FUNC_NONE, 2000, 1, 1, 0, 16383, 15, 31, 1, '{2000, 1, 1, 0, 1, 0, 1}},
        // year zero
        '{FUNC_ADD, 0, 6, 15, 5, 1, 1, 1, 1, '{0, 6, 15, 0, 1, 0, 1}},
        // every first-date and count bit high
        '{FUNC_SUB, 16383, 15, 31, 65535, 1, 1, 1, 1, '{16383, 15, 31, 0, 0, 0, 1}},
        // month zero
        '{FUNC_ADD, 2000, 0, 10, 1, 2000, 0, 10, 1, '{2000, 0, 10, 0, 0, 1, 1}},
        // day zero
        '{FUNC_DIFF, 2000, 3, 0, 0, 1999, 1, 1, 1, '{2000, 3, 0, 0, 0, 0, 1}},
        // feb 29 in a century year that is not leap
        '{FUNC_ADD, 1900, 2, 29, 1, 1900, 3, 1, 1, '{1900, 2, 29, 0, 1, 0, 1}},
        // day past a 30-day month
        '{FUNC_SUB, 2023, 4, 31, 1, 2023, 4, 30, 1, '{2023, 4, 31, 0, 0, 0, 1}},
        // zero shift at the first day of the calendar
        '{FUNC_ADD, 1, 1, 1, 0, 1, 1, 1, 1, '{1, 1, 1, 0, 0, 1, 0}},
        // subtract below the first day
        '{FUNC_SUB, 1, 1, 1, 1, 1, 1, 1, 1, '{1, 1, 1, 0, 0, 1, 1}},
        // add past the last day
        '{FUNC_ADD, 9999, 12, 31, 1, 1, 1, 1, 1, '{9999, 12, 31, 0, 0, 0, 1}},
        // widest difference
        '{FUNC_DIFF, 9999, 12, 31, 0, 1, 1, 1, 1, '{9999, 12, 31, 3652058, 0, 0, 0}},
        // negative difference
        '{FUNC_DIFF, 1, 1, 1, 0, 1, 1, 2, 1, '{1, 1, 1, 0, 1, 0, 1}},
        // bad second date in a difference
        '{FUNC_DIFF, 2000, 1, 1, 0, 1999, 2, 29, 1, '{2000, 1, 1, 0, 0, 0, 1}},
        // zero difference on a leap day
        '{FUNC_DIFF, 2024, 2, 29, 0, 2024, 2, 29, 1, '{2024, 2, 29, 0, 0, 1, 0}},
        // century rule: 1900 has no feb 29
        '{FUNC_ADD, 1900, 2, 28, 1, 1900, 2, 28, 1, '{1900, 3, 1, 0, 0, 1, 0}},
        // 400-year rule: 2000 has feb 29
        '{FUNC_ADD, 2000, 2, 28, 1, 2000, 2, 28, 1, '{2000, 2, 29, 0, 0, 1, 0}},
        // borrow from a leap february
        '{FUNC_SUB, 2024, 3, 1, 1, 2024, 3, 1, 1, '{2024, 2, 29, 0, 0, 1, 0}},
        // borrow across a year boundary
        '{FUNC_SUB, 2000, 1, 1, 1, 1999, 12, 31, 1, '{1999, 12, 31, 0, 0, 0, 0}},
        // land exactly on the last and on the first day, and a one-day difference
        '{FUNC_ADD, 9999, 12, 30, 1, 9999, 12, 31, 1, '{9999, 12, 31, 0, 1, 0, 0}},
        '{FUNC_SUB, 1, 1, 2, 1, 1, 1, 1, 1, '{1, 1, 1, 0, 0, 0, 0}},
        '{FUNC_DIFF, 2000, 1, 1, 0, 1999, 12, 31, 1, '{2000, 1, 1, 1, 0, 0, 0}},
        // full counts and mid-range dates, predicted
        '{FUNC_ADD, 2000, 1, 1, 65535, 2000, 1, 1, 0, '0},
        '{FUNC_SUB, 9999, 12, 31, 65535, 9999, 12, 31, 0, '0},
        '{FUNC_DIFF, 2024, 7, 4, 0, 1970, 1, 1, 0, '0},
        '{FUNC_ADD, 2023, 12, 31, 60, 2024, 2, 29, 0, '0}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_stall;
    logic [1:0]  i_func        = FUNC_ADD;
    logic [13:0] i_year        = '0;
    logic [3:0]  i_month       = '0;
    logic [4:0]  i_day         = '0;
    logic [15:0] i_day_count   = '0;
    logic [13:0] i_other_year  = '0;
    logic [3:0]  i_other_month = '0;
    logic [4:0]  i_other_day   = '0;
    logic        o_valid;
    logic        i_stall       = 1'b0;
    logic [13:0] o_res_year;
    logic [3:0]  o_res_month;
    logic [4:0]  o_res_day;
    logic [21:0] o_day_difference;
    logic        o_is_less;
    logic        o_is_equal;
    logic        o_error;

    // expectation that rides along with the beat on the input channel
    logic         cur_typed = 1'b0;
    date_result_t cur_want  = '0;

    logic calm = 1'b0;   // no idling on either side once set

    date_result_t expected_dates [$];
    int unsigned  beats_in     = 0;
    int unsigned  dir_beats    = 0;
    int unsigned  results_seen = 0;
    int unsigned  error_flags  = 0;
    int unsigned  mismatches   = 0;
    int unsigned  idle_cycles  = 0;
    int unsigned  stall_left   = 0;
    int unsigned  func_seen [4] = '{0, 0, 0, 0};

    gregorian_date_arithmetic_top #(
        .YEAR_MAX(YEAR_LIMIT)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_year           (i_year),
        .i_month          (i_month),
        .i_day            (i_day),
        .i_day_count      (i_day_count),
        .i_other_year     (i_other_year),
        .i_other_month    (i_other_month),
        .i_other_day      (i_other_day),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_res_year       (o_res_year),
        .o_res_month      (o_res_month),
        .o_res_day        (o_res_day),
        .o_day_difference (o_day_difference),
        .o_is_less        (o_is_less),
        .o_is_equal       (o_is_equal),
        .o_error          (o_error)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // calendar predictor
    // ------------------------------------------------------------------------

    function automatic bit is_leap(int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    // zero for a month number outside 1..12
    function automatic int unsigned month_days(int unsigned y, int unsigned m);
        int unsigned len;
        case (m)
            2: len = is_leap(y) ? 29 : 28;
            4, 6, 9, 11: len = 30;
            1, 3, 5, 7, 8, 10, 12: len = 31;
            default: len = 0;
        endcase
        return len;
    endfunction

    function automatic bit date_ok(int unsigned y, int unsigned m, int unsigned d);
        return y >= 1 && y <= YEAR_LIMIT && m >= 1 && m <= 12 &&
               d >= 1 && d <= month_days(y, m);
    endfunction

    // orders raw fields year first, then month, then day
    function automatic int unsigned date_key(int unsigned y, int unsigned m,
                                             int unsigned d);
        return (y << 9) | (m << 5) | d;
    endfunction

    // days since 0001-01-01
    function automatic int unsigned day_number(int unsigned y, int unsigned m,
                                               int unsigned d);
        int unsigned past;
        int unsigned n;
        past = y - 1;
        n = 365 * past + past / 4 - past / 100 + past / 400;
        for (int unsigned i = 1; i < m; i++) begin
            n += month_days(y, i);
        end
        return n + d - 1;
    endfunction

    // peel off 400-year eras, centuries, leap quads and years, then months
    function automatic cal_date_t number_to_date(int unsigned n);
        cal_date_t dt;
        int unsigned era, cen, quad, yr;
        era = n / 146097;
        n = n % 146097;
        cen = n / 36524;
        if (cen == 4) begin
            cen = 3;
        end
        n -= cen * 36524;
        quad = n / 1461;
        n = n % 1461;
        yr = n / 365;
        if (yr == 4) begin
            yr = 3;
        end
        n -= yr * 365;
        dt.y = era * 400 + cen * 100 + quad * 4 + yr + 1;
        dt.m = 1;
        while (dt.m < 12 && n >= month_days(dt.y, dt.m)) begin
            n -= month_days(dt.y, dt.m);
            dt.m++;
        end
        dt.d = n + 1;
        return dt;
    endfunction

    function automatic date_result_t predict_date(date_beat_t b);
        date_result_t r;
        cal_date_t    shifted;
        int unsigned  y1, m1, d1, y2, m2, d2, cnt;
        int unsigned  first_key, second_key, n;
        logic         bad;
        y1  = 32'(b.year);
        m1  = 32'(b.month);
        d1  = 32'(b.day);
        y2  = 32'(b.other_year);
        m2  = 32'(b.other_month);
        d2  = 32'(b.other_day);
        cnt = 32'(b.count);
        r = '0;
        r.year  = b.year;
        r.month = b.month;
        r.day   = b.day;
        first_key  = date_key(y1, m1, d1);
        second_key = date_key(y2, m2, d2);
        r.less = first_key < second_key;
        r.same = first_key == second_key;
        bad = 1'b0;
        if (b.func == FUNC_NONE || !date_ok(y1, m1, d1)) begin
            bad = 1'b1;
        end else if (b.func == FUNC_DIFF) begin
            if (!date_ok(y2, m2, d2) || r.less) begin
                bad = 1'b1;
            end else begin
                r.span = 22'(day_number(y1, m1, d1) - day_number(y2, m2, d2));
            end
        end else begin
            n = day_number(y1, m1, d1);
            if (b.func == FUNC_ADD) begin
                n += cnt;
            end else if (cnt > n) begin
                bad = 1'b1;
            end else begin
                n -= cnt;
            end
            if (!bad) begin
                shifted = number_to_date(n);
                if (shifted.y > YEAR_LIMIT) begin
                    bad = 1'b1;
                end else begin
                    r.year  = 14'(shifted.y);
                    r.month = 4'(shifted.m);
                    r.day   = 5'(shifted.d);
                end
            end
        end
        r.err = bad;
        if (bad) begin
            r.span = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // random beats
    // ------------------------------------------------------------------------

    // leans on both ends of the year range
    function automatic int unsigned pick_year();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return $urandom_range(1, 3);
        end else if (r == 1) begin
            return $urandom_range(YEAR_LIMIT - 2, YEAR_LIMIT);
        end
        return $urandom_range(1, YEAR_LIMIT);
    endfunction

    function automatic date_beat_t random_beat();
        date_beat_t  b;
        int unsigned y, m, d, y2, m2, d2, t;
        b = '0;
        if ($urandom_range(0, 99) < 15) begin
            // raw noise over the full field widths, mostly bad dates
            b.func        = 2'($urandom);
            b.year        = 14'($urandom);
            b.month       = 4'($urandom);
            b.day         = 5'($urandom);
            b.count       = 16'($urandom);
            b.other_year  = 14'($urandom);
            b.other_month = 4'($urandom);
            b.other_day   = 5'($urandom);
            return b;
        end
        b.func = 2'($urandom_range(0, 2));
        y = pick_year();
        m = $urandom_range(1, 12);
        d = $urandom_range(1, month_days(y, m));
        t = $urandom_range(0, 9);
        if (t == 0) begin
            y2 = y;
            m2 = m;
            d2 = d;
        end else begin
            // same year often, so month and day decide the compare
            y2 = (t < 4) ? y : pick_year();
            m2 = $urandom_range(1, 12);
            d2 = $urandom_range(1, month_days(y2, m2));
        end
        // most differences are made non-negative so they reach the walk
        if (b.func == FUNC_DIFF && $urandom_range(0, 3) != 0 &&
            date_key(y, m, d) < date_key(y2, m2, d2)) begin
            {y, m, d, y2, m2, d2} = {y2, m2, d2, y, m, d};
        end
        b.year        = 14'(y);
        b.month       = 4'(m);
        b.day         = 5'(d);
        b.other_year  = 14'(y2);
        b.other_month = 4'(m2);
        b.other_day   = 5'(d2);
        b.count = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 40))
                                               : 16'($urandom_range(0, 65535));
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // input side: optional idle burst, then hold the beat until taken
    // ------------------------------------------------------------------------

    task automatic drive_beat(input date_beat_t b);
        int unsigned gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 30) begin
            gap = $urandom_range(1, 19);
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= b.func;
        i_year        <= b.year;
        i_month       <= b.month;
        i_day         <= b.day;
        i_day_count   <= b.count;
        i_other_year  <= b.other_year;
        i_other_month <= b.other_month;
        i_other_day   <= b.other_day;
        cur_typed     <= b.typed;
        cur_want      <= b.want;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // both handshakes are sampled here, so the order of a push and a pop in
    // one cycle never depends on the simulator
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        date_result_t got, want;
        date_beat_t   taken;
        logic         out_beat, in_beat;
        out_beat = i_rst_n && o_valid && !i_stall;
        in_beat  = i_rst_n && i_valid && !o_stall;

        // result beat against the oldest expectation
        if (out_beat) begin
            got = '{o_res_year, o_res_month, o_res_day, o_day_difference,
                    o_is_less, o_is_equal, o_error};
            results_seen++;
            if (o_error) begin
                error_flags++;
            end
            if (expected_dates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d arrived with nothing expected", results_seen);
                end
            end else begin
                want = expected_dates.pop_front();
                if (got.year !== want.year || got.month !== want.month ||
                    got.day !== want.day || got.span !== want.span ||
                    got.less !== want.less || got.same !== want.same ||
                    got.err !== want.err) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch on result %0d", results_seen);
                        $display("  expected %0d-%0d-%0d diff %0d lt %0b eq %0b err %0b",
                                 want.year, want.month, want.day, want.span,
                                 want.less, want.same, want.err);
                        $display("  actual   %0d-%0d-%0d diff %0d lt %0b eq %0b err %0b",
                                 got.year, got.month, got.day, got.span,
                                 got.less, got.same, got.err);
                    end
                end
            end
        end

        // accepted input beat: typed rows keep their own result
        if (in_beat) begin
            taken = '{i_func, i_year, i_month, i_day, i_day_count, i_other_year,
                      i_other_month, i_other_day, cur_typed, cur_want};
            expected_dates.push_back(cur_typed ? cur_want : predict_date(taken));
            func_seen[i_func]++;
            beats_in++;
        end

        // output stall comes in bursts of random length
        if (!i_rst_n || calm) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if ($urandom_range(0, 99) < 20) begin
            stall_left <= $urandom_range(0, 18);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end

        // watchdog on cycles where neither channel moves a beat
        if (!i_rst_n || in_beat || out_beat) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // sequence: reset, directed table, random beats, drain
    // ------------------------------------------------------------------------

    initial begin
        date_beat_t b;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            drive_beat(DIRECTED_ROWS[r]);
        end
        dir_beats = DIR_ROWS;

        for (int k = 0; k < RANDOM_BEATS; k++) begin
            if (k == RANDOM_BEATS - CALM_BEATS) begin
                calm <= 1'b1;
            end
            b = random_beat();
            drive_beat(b);
        end
        i_valid <= 1'b0;

        // drain, then leave room for any stray result
        while (expected_dates.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d beats (%0d directed), %0d results checked, %0d with error",
                 beats_in, dir_beats, results_seen, error_flags);
        $display("selectors: %0d add, %0d subtract, %0d difference, %0d unused",
                 func_seen[FUNC_ADD], func_seen[FUNC_SUB], func_seen[FUNC_DIFF],
                 func_seen[FUNC_NONE]);
        if (mismatches == 0 && expected_dates.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results still expected",
                     mismatches, expected_dates.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
